// File: sv/mf3_pkg.sv
// ============================================================================
// mf3_pkg: shared constants, types and helpers of the 3x3 mean filter
// Row store geometry, field widths, register indexes and the divide by nine.
// ============================================================================
package mf3_pkg;

    localparam int MAX_WIDTH   = 1024;
    localparam int COL_W       = $clog2(MAX_WIDTH);
    localparam int ROW_W       = 16;
    localparam int WIDTH_REG_W = 11;
    localparam int DATA_W      = 16;
    localparam int PIX_W       = 8;
    localparam int COLSUM_W    = 10;
    localparam int SUM_W       = 12;
    localparam int RES_MAX     = 4;
    localparam int CNT_W       = 3;
    localparam int IDX_W       = 2;

    localparam logic [WIDTH_REG_W-1:0] WIDTH_RESET  = 11'd640;
    localparam logic [ROW_W-1:0]       HEIGHT_RESET = 16'd480;

    // ceil(2^16 / 9); exact floor(s / 9) for every 12-bit window sum up to 9 * 255
    localparam logic [12:0] RECIP9 = 13'd7282;

    typedef enum logic [0:0] {
        REG_IMAGE_WIDTH  = 1'b0,
        REG_IMAGE_HEIGHT = 1'b1
    } cfg_reg_t;

    typedef logic [PIX_W-1:0] pix_t;

    // one pixel waiting on its row store read
    typedef struct packed {
        pix_t             pixel;
        logic [COL_W-1:0] col;
        logic             first_row;
        logic             last_row;
        logic             last_col;
        logic             fwd;
        pix_t             fwd_older;
        pix_t             fwd_newer;
    } b_item_t;

    // results caused by one pixel, in delivery order
    typedef struct packed {
        pix_t [RES_MAX-1:0] means;
        logic [CNT_W-1:0]   count;
        logic               eof;
    } res_pack_t;

    function automatic pix_t div9(input logic [SUM_W-1:0] s);
        logic [24:0] p;
        p = {13'd0, s} * {12'd0, RECIP9};
        return p[23:16];
    endfunction

endpackage

// File: sv/mf3_line_buffer.sv
// ============================================================================
// mf3_line_buffer: the two row stores
// Older and newer row of pixels, one shared read address with registered
// read data, one shared write address.
// ============================================================================
module mf3_line_buffer (
    input  logic                      clk,
    input  logic                      rd_en,
    input  logic [mf3_pkg::COL_W-1:0] rd_addr,
    input  logic                      wr_en,
    input  logic [mf3_pkg::COL_W-1:0] wr_addr,
    input  mf3_pkg::pix_t             wr_older,
    input  mf3_pkg::pix_t             wr_newer,
    output mf3_pkg::pix_t             older_q,
    output mf3_pkg::pix_t             newer_q
);
    import mf3_pkg::*;

    pix_t older_mem [MAX_WIDTH];
    pix_t newer_mem [MAX_WIDTH];
    pix_t older_q_reg;
    pix_t newer_q_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            older_mem[wr_addr] <= wr_older;
            newer_mem[wr_addr] <= wr_newer;
        end
    end

    // read returns the contents before a write at the same edge
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            older_q_reg <= older_mem[rd_addr];
            newer_q_reg <= newer_mem[rd_addr];
        end
    end

    assign older_q = older_q_reg;
    assign newer_q = newer_q_reg;

endmodule

// File: sv/mf3_window.sv
// ============================================================================
// mf3_window: 3x3 window and neighborhood means
// Shifts a new pixel column into the window and works out the up to four
// means that the pixel releases.
// ============================================================================
module mf3_window (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                load,
    input  mf3_pkg::b_item_t    item,
    input  mf3_pkg::pix_t       top,
    input  mf3_pkg::pix_t       mid,
    output mf3_pkg::res_pack_t  pack
);
    import mf3_pkg::*;

    pix_t win_t_reg [3];
    pix_t win_m_reg [3];
    pix_t win_b_reg [3];
    pix_t win_t_next [3];
    pix_t win_m_next [3];
    pix_t win_b_next [3];

    logic [COLSUM_W-1:0] inner_col [3];
    logic [COLSUM_W-1:0] bottom_col [3];
    logic [SUM_W-1:0]    inner_full;
    logic [SUM_W-1:0]    inner_edge;
    logic [SUM_W-1:0]    bottom_full;
    logic [SUM_W-1:0]    bottom_edge;

    // first column of a row fills the whole window (left edge replicated)
    always_comb
    begin
        if (item.col == '0)
        begin
            for (int k = 0; k < 3; k++)
            begin
                win_t_next[k] = top;
                win_m_next[k] = mid;
                win_b_next[k] = item.pixel;
            end
        end
        else
        begin
            win_t_next[0] = win_t_reg[1];
            win_m_next[0] = win_m_reg[1];
            win_b_next[0] = win_b_reg[1];
            win_t_next[1] = win_t_reg[2];
            win_m_next[1] = win_m_reg[2];
            win_b_next[1] = win_b_reg[2];
            win_t_next[2] = top;
            win_m_next[2] = mid;
            win_b_next[2] = item.pixel;
        end
    end

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            inner_col[k]  = COLSUM_W'(win_t_next[k]) + COLSUM_W'(win_m_next[k])
                          + COLSUM_W'(win_b_next[k]);
            // bottom row replicated below the last row
            bottom_col[k] = COLSUM_W'(win_m_next[k]) + COLSUM_W'(win_b_next[k])
                          + COLSUM_W'(win_b_next[k]);
        end
        inner_full  = SUM_W'(inner_col[0]) + SUM_W'(inner_col[1]) + SUM_W'(inner_col[2]);
        inner_edge  = SUM_W'(inner_col[1]) + SUM_W'(inner_col[2]) + SUM_W'(inner_col[2]);
        bottom_full = SUM_W'(bottom_col[0]) + SUM_W'(bottom_col[1])
                    + SUM_W'(bottom_col[2]);
        bottom_edge = SUM_W'(bottom_col[1]) + SUM_W'(bottom_col[2])
                    + SUM_W'(bottom_col[2]);
    end

    // pack results: row above first, then the last row itself
    always_comb
    begin
        logic [CNT_W-1:0] n;
        n = '0;
        pack.means = '0;
        if (!item.first_row && item.col != '0)
        begin
            pack.means[n[IDX_W-1:0]] = div9(inner_full);
            n = CNT_W'(n + 1'b1);
        end
        if (!item.first_row && item.last_col)
        begin
            pack.means[n[IDX_W-1:0]] = div9(inner_edge);
            n = CNT_W'(n + 1'b1);
        end
        if (item.last_row && item.col != '0)
        begin
            pack.means[n[IDX_W-1:0]] = div9(bottom_full);
            n = CNT_W'(n + 1'b1);
        end
        if (item.last_row && item.last_col)
        begin
            pack.means[n[IDX_W-1:0]] = div9(bottom_edge);
            n = CNT_W'(n + 1'b1);
        end
        pack.count = n;
        pack.eof   = item.last_row && item.last_col;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < 3; k++)
            begin
                win_t_reg[k] <= '0;
                win_m_reg[k] <= '0;
                win_b_reg[k] <= '0;
            end
        end
        else if (load)
        begin
            for (int k = 0; k < 3; k++)
            begin
                win_t_reg[k] <= win_t_next[k];
                win_m_reg[k] <= win_m_next[k];
                win_b_reg[k] <= win_b_next[k];
            end
        end
    end

endmodule

// File: sv/mf3_out_queue.sv
// ============================================================================
// mf3_out_queue: result register
// Holds the results of one pixel and hands them out one beat at a time.
// ============================================================================
module mf3_out_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                load,
    input  mf3_pkg::res_pack_t  pack,
    input  logic                out_stall,
    output logic                out_valid,
    output mf3_pkg::pix_t       mean_value,
    output logic                last_in_run,
    output logic                end_of_frame,
    output logic                free
);
    import mf3_pkg::*;

    pix_t [RES_MAX-1:0]  means_reg;
    logic [CNT_W-1:0]    count_reg;
    logic [IDX_W-1:0]    idx_reg;
    logic                eof_reg;
    logic                valid_reg;
    logic                is_last;
    logic                take;

    assign is_last = (CNT_W'(idx_reg) + CNT_W'(1)) == count_reg;
    assign take    = valid_reg && !out_stall;
    assign free    = !valid_reg || (take && is_last);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
            count_reg <= '0;
        end
        else if (load)
        begin
            valid_reg <= pack.count != '0;
            idx_reg   <= '0;
            count_reg <= pack.count;
        end
        else if (take)
        begin
            if (is_last)
                valid_reg <= 1'b0;
            else
                idx_reg <= IDX_W'(idx_reg + 1'b1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            means_reg <= pack.means;
            eof_reg   <= pack.eof;
        end
    end

    assign out_valid    = valid_reg;
    assign mean_value   = means_reg[idx_reg];
    assign last_in_run  = is_last;
    assign end_of_frame = is_last && eof_reg;

endmodule

// File: sv/mean_filter_3x3_replicate.sv
// ============================================================================
// mean_filter_3x3_replicate: streaming 3x3 box mean, replicated borders
// Raster pixels in, floor(sum/9) per pixel out, one row behind the input.
// ============================================================================
//
//  Channel   Handshake              Payload
//  -------   --------------------   ------------------------------------------
//  input     in_valid / in_stall    pixel
//  output    out_valid / out_stall  mean_value, last_in_run, end_of_frame
//  config    cfg_we                 cfg_index, cfg_data
//
//  One pixel per clock while in_stall is low. A pixel waits in the accept
//  register for the row store read, then loads the window and result
//  register. The result register hands out one beat a clock while out_stall
//  is low, so a row end (two results) or last-row pixel (up to four) holds the
//  input until its results drain. Reset empties the pipe and zeroes the window;
//  the row stores need no clearing. in_stall follows out_stall in the same cycle.
//
module mean_filter_3x3_replicate (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  mf3_pkg::pix_t          pixel,
    output logic                   out_valid,
    input  logic                   out_stall,
    output mf3_pkg::pix_t          mean_value,
    output logic                   last_in_run,
    output logic                   end_of_frame,
    input  logic                   cfg_we,
    input  logic                   cfg_index,
    input  logic [mf3_pkg::DATA_W-1:0] cfg_data
);
    import mf3_pkg::*;

    logic [WIDTH_REG_W-1:0] width_reg;
    logic [ROW_W-1:0]       height_reg;
    logic [COL_W-1:0]       col_count_reg;
    logic [COL_W-1:0]       col_count_next;
    logic [ROW_W-1:0]       row_count_reg;
    logic [ROW_W-1:0]       row_count_next;

    logic [COL_W-1:0]       w_last;
    logic [ROW_W-1:0]       h_last;
    logic [COL_W-1:0]       col_a;
    logic [ROW_W-1:0]       row_a;
    logic                   first_a;
    logic                   last_row_a;
    logic                   last_col_a;

    b_item_t                b_reg;
    b_item_t                b_next;
    logic                   b_valid_reg;
    logic                   b_adv;
    logic                   in_take;
    logic                   q_free;

    pix_t                   older_q;
    pix_t                   newer_q;
    pix_t                   top_b;
    pix_t                   mid_b;
    res_pack_t              pack;

    // ---------------- configuration ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_IMAGE_WIDTH:  width_reg  <= cfg_data[WIDTH_REG_W-1:0];
                REG_IMAGE_HEIGHT: height_reg <= cfg_data[ROW_W-1:0];
                default:          width_reg  <= width_reg;
            endcase
        end
    end

    // zero width acts as one, oversize as the store depth
    always_comb
    begin
        if (width_reg == '0)
            w_last = '0;
        else if (int'(width_reg) > MAX_WIDTH)
            w_last = COL_W'(MAX_WIDTH - 1);
        else
            w_last = COL_W'(width_reg - 1'b1);
        h_last = (height_reg == '0) ? '0 : ROW_W'(height_reg - 1'b1);
    end

    // ---------------- accept stage ----------------
    always_comb
    begin
        col_a      = (col_count_reg > w_last) ? w_last : col_count_reg;
        row_a      = (row_count_reg > h_last) ? h_last : row_count_reg;
        first_a    = row_a == '0;
        last_row_a = row_a == h_last;
        last_col_a = col_a == w_last;

        if (last_col_a)
        begin
            col_count_next = '0;
            row_count_next = last_row_a ? '0 : ROW_W'(row_a + 1'b1);
        end
        else
        begin
            col_count_next = COL_W'(col_a + 1'b1);
            row_count_next = row_a;
        end
    end

    assign b_adv    = b_valid_reg && q_free;
    assign in_stall = b_valid_reg && !b_adv;
    assign in_take  = in_valid && !in_stall;

    // same column written by the leaving pixel at this edge: the read sees stale data
    always_comb
    begin
        b_next.pixel     = pixel;
        b_next.col       = col_a;
        b_next.first_row = first_a;
        b_next.last_row  = last_row_a;
        b_next.last_col  = last_col_a;
        b_next.fwd       = b_adv && (b_reg.col == col_a);
        b_next.fwd_older = mid_b;
        b_next.fwd_newer = b_reg.pixel;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_count_reg <= '0;
            row_count_reg <= '0;
            b_valid_reg   <= 1'b0;
        end
        else
        begin
            if (in_take)
            begin
                col_count_reg <= col_count_next;
                row_count_reg <= row_count_next;
                b_valid_reg   <= 1'b1;
            end
            else if (b_adv)
            begin
                b_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
            b_reg <= b_next;
    end

    // ---------------- row stores ----------------
    mf3_line_buffer u_line_buffer (
        .clk      (clk),
        .rd_en    (in_take),
        .rd_addr  (col_a),
        .wr_en    (b_adv),
        .wr_addr  (b_reg.col),
        .wr_older (mid_b),
        .wr_newer (b_reg.pixel),
        .older_q  (older_q),
        .newer_q  (newer_q)
    );

    // first row: rows above replicate the pixel itself
    always_comb
    begin
        if (b_reg.first_row)
        begin
            top_b = b_reg.pixel;
            mid_b = b_reg.pixel;
        end
        else if (b_reg.fwd)
        begin
            top_b = b_reg.fwd_older;
            mid_b = b_reg.fwd_newer;
        end
        else
        begin
            top_b = older_q;
            mid_b = newer_q;
        end
    end

    // ---------------- window and results ----------------
    mf3_window u_window (
        .clk   (clk),
        .rst_n (rst_n),
        .load  (b_adv),
        .item  (b_reg),
        .top   (top_b),
        .mid   (mid_b),
        .pack  (pack)
    );

    mf3_out_queue u_out_queue (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (b_adv),
        .pack         (pack),
        .out_stall    (out_stall),
        .out_valid    (out_valid),
        .mean_value   (mean_value),
        .last_in_run  (last_in_run),
        .end_of_frame (end_of_frame),
        .free         (q_free)
    );

    // ---------------- assertions ----------------
    a_fwd_on_same_col: assert property (@(posedge clk) disable iff (!rst_n)
        (b_adv && in_take && (b_reg.col == col_a)) |=> (b_valid_reg && b_reg.fwd))
        else $error("row store bypass not taken on same-column follow-up");

    a_eof_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && end_of_frame) |-> last_in_run)
        else $error("end_of_frame on a beat that is not last of its run");

    a_frame_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        (in_take && last_col_a && last_row_a) |=>
            (col_count_reg == '0 && row_count_reg == '0))
        else $error("position counters did not wrap at frame end");

endmodule
